// ----- rtl/core/plc_pkg.sv -----
// Shared constants and elaboration-time helpers for the Phong light contribution core.
// No dependencies; imported by the core, the power unit and the port checker.
package plc_pkg;

    localparam int COMPONENT_BITS_DEF = 16;

    // Stage counts of the fixed parts of the pipeline.
    localparam int FRONT_STAGES = 6;
    localparam int DIV_STAGES   = 17;
    localparam int POW_LAT      = 36;
    localparam int COLOR_STAGES = 4;

    localparam logic [17:0] OUT_MAX = 18'h3FFFF;

    localparam logic [15:0] DIFFUSE_ALBEDO_RST  = 16'd0;
    localparam logic [15:0] SPECULAR_ALBEDO_RST = 16'd0;
    localparam logic [15:0] SHININESS_RST       = 16'd256;

    // Bits of the reflected vector length for a given component width.
    function automatic int plc_root_bits(input int cb);
        return cb + 5;
    endfunction

    // Cycles from an accepted request to its result strobe.
    function automatic int plc_latency(input int cb);
        return FRONT_STAGES + plc_root_bits(cb) + DIV_STAGES + POW_LAT + COLOR_STAGES;
    endfunction

    // Floor square root, evaluated at elaboration only.
    function automatic logic [63:0] plc_isqrt(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] test;
        rem  = x;
        root = '0;
        for (int k = 31; k >= 0; k--)
        begin
            test = (root << (k + 1)) + (64'd1 << (2 * k));
            if (rem >= test)
            begin
                rem  = rem - test;
                root = root | (64'd1 << k);
            end
        end
        return root;
    endfunction

    // 2^(-2^-k) in Q.30 for k >= 1, built by repeated square roots of one half; k = 0 gives one.
    function automatic logic [30:0] plc_exp_const(input int k);
        logic [63:0] v;
        v = 64'd1 << 29;
        if (k == 0)
        begin
            return 31'h4000_0000;
        end
        for (int j = 1; j <= 16; j++)
        begin
            if (j <= k)
            begin
                v = plc_isqrt(v << 30);
            end
        end
        return v[30:0];
    endfunction

endpackage

// ----- rtl/core/plc_pow_unit.sv -----
// Pipelined power unit: raises a Q.16 cosine to a Q8.8 exponent via log2 and exp2.
// Depends on plc_pkg for the exp2 constants.
module plc_pow_unit
    import plc_pkg::*;
(
    input  logic        clk,
    input  logic [16:0] c16,
    input  logic        kill,
    input  logic [15:0] shininess,
    output logic [16:0] spec
);

    typedef enum logic [1:0] {SC_CALC, SC_ZERO, SC_ONE} spec_code_t;

    typedef struct packed {
        spec_code_t  code;
        logic [3:0]  p;
        logic [30:0] m;
        logic [15:0] f;
    } log_t;

    typedef struct packed {
        spec_code_t  code;
        logic [20:0] lg;
    } lgv_t;

    typedef struct packed {
        spec_code_t  code;
        logic [4:0]  q;
        logic [15:0] r;
        logic [30:0] v;
    } exp_t;

    log_t        log_reg [17];
    log_t        log0_next;
    lgv_t        lgv_reg;
    lgv_t        lgv_next;
    exp_t        exp_reg [17];
    exp_t        exp0_next;
    logic [16:0] spec_reg;
    logic [16:0] spec_next;

    // Normalize the cosine into [1, 2) and sort out the cases with a fixed answer.
    always_comb
    begin
        logic [46:0] wide;
        log0_next.p = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (c16[i])
            begin
                log0_next.p = 4'(i);
            end
        end
        wide = 47'(c16[15:0]) << (5'd30 - {1'b0, log0_next.p});
        log0_next.m = wide[30:0];
        log0_next.f = '0;
        if (kill)
        begin
            log0_next.code = SC_ZERO;
        end
        else if (shininess == 16'd0)
        begin
            log0_next.code = SC_ONE;
        end
        else if (c16 == 17'd0)
        begin
            log0_next.code = SC_ZERO;
        end
        else if (c16[16])
        begin
            log0_next.code = SC_ONE;
        end
        else
        begin
            log0_next.code = SC_CALC;
        end
    end

    always_ff @(posedge clk)
    begin
        log_reg[0] <= log0_next;
    end

    // One fraction bit of the logarithm per stage, by squaring the mantissa.
    for (genvar i = 1; i <= 16; i++)
    begin : g_square
        log_t sq_next;
        always_comb
        begin
            logic [61:0] prod;
            logic [31:0] sqv;
            prod    = 62'(log_reg[i-1].m) * 62'(log_reg[i-1].m);
            sqv     = prod[61:30];
            sq_next = log_reg[i-1];
            if (sqv[31])
            begin
                sq_next.m = sqv[31:1];
                sq_next.f = {log_reg[i-1].f[14:0], 1'b1};
            end
            else
            begin
                sq_next.m = sqv[30:0];
                sq_next.f = {log_reg[i-1].f[14:0], 1'b0};
            end
        end
        always_ff @(posedge clk)
        begin
            log_reg[i] <= sq_next;
        end
    end

    always_comb
    begin
        lgv_next.code = log_reg[16].code;
        lgv_next.lg   = {5'(5'd16 - {1'b0, log_reg[16].p}), 16'b0} - 21'(log_reg[16].f);
    end

    always_ff @(posedge clk)
    begin
        lgv_reg <= lgv_next;
    end

    // Scale the logarithm by the exponent; a result of 2^-17 or less flushes to zero.
    always_comb
    begin
        logic [36:0] e37;
        logic [28:0] e;
        e37            = 37'(lgv_reg.lg) * 37'(shininess);
        e              = e37[36:8];
        exp0_next.code = lgv_reg.code;
        if ((lgv_reg.code == SC_CALC) && (e[28:16] >= 13'd17))
        begin
            exp0_next.code = SC_ZERO;
        end
        exp0_next.q = e[20:16];
        exp0_next.r = e[15:0];
        exp0_next.v = 31'h4000_0000;
    end

    always_ff @(posedge clk)
    begin
        exp_reg[0] <= exp0_next;
    end

    // exp2 of the fraction: one constant multiply per set bit, MSB first.
    for (genvar i = 1; i <= 16; i++)
    begin : g_exp
        localparam logic [30:0] EXP_K = plc_exp_const(i);
        exp_t ex_next;
        always_comb
        begin
            logic [61:0] prod;
            prod    = 62'(exp_reg[i-1].v) * 62'(EXP_K);
            ex_next = exp_reg[i-1];
            if (exp_reg[i-1].r[16-i])
            begin
                ex_next.v = prod[60:30];
            end
        end
        always_ff @(posedge clk)
        begin
            exp_reg[i] <= ex_next;
        end
    end

    always_comb
    begin
        case (exp_reg[16].code)
            SC_ONE:  spec_next = 17'h10000;
            SC_ZERO: spec_next = '0;
            SC_CALC: spec_next = 17'(exp_reg[16].v >> (5'd14 + exp_reg[16].q));
            default: spec_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        spec_reg <= spec_next;
    end

    assign spec = spec_reg;

endmodule

// ----- rtl/core/phong_light_contribution_core.sv -----
// Top level of the Phong light contribution core: one light's diffuse plus specular colour.
// Depends on plc_pkg and instantiates plc_pow_unit for the shininess power.
//
//   Channel    Direction  Handshake              Payload
//   request    in         start high, busy low   normal/light/view vectors, colours, visibility
//   result     out        done, one cycle        add_red, add_green, add_blue
//   config     in         cfg_we                 cfg_addr, cfg_data
//
// A new request may enter in every cycle. The pipeline includes the bit-per-stage
// square root of the reflected vector (COMPONENT_BITS + 5 stages), the 17-stage
// divider for the cosine and the 36-stage power unit with its 16 squaring and
// 16 exp2 multiply stages.
// Reset clears the valid line and loads the register defaults; the data path needs none.
// Nothing stalls: the receiver takes every result, so busy is always low.
module phong_light_contribution_core
    import plc_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    input  logic [47:0] normal_xyz,
    input  logic [47:0] light_dir_xyz,
    input  logic [47:0] view_dir_xyz,
    input  logic [15:0] light_red,
    input  logic [15:0] light_green,
    input  logic [15:0] light_blue,
    input  logic [15:0] surface_red,
    input  logic [15:0] surface_green,
    input  logic [15:0] surface_blue,
    input  logic [16:0] visibility,
    output logic        done,
    output logic [17:0] add_red,
    output logic [17:0] add_green,
    output logic [17:0] add_blue
);

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_DIFFUSE_ALBEDO  = 2'd0;
    localparam logic [1:0] CFG_SPECULAR_ALBEDO = 2'd1;
    localparam logic [1:0] CFG_SHININESS       = 2'd2;

    // Widths of the vector path, all following from the component width.
    localparam int CB   = COMPONENT_BITS;
    localparam int F    = CB - 2;
    localparam int PW   = 3 * CB;
    localparam int XW   = (PW > 48) ? PW : 48;
    localparam int PW2  = 2 * CB;
    localparam int DW   = 2 * CB + 1;
    localparam int TW   = CB + 3;
    localparam int QW   = 2 * CB + 3;
    localparam int MW   = CB + 5;
    localparam int SQW  = 2 * MW;
    localparam int MVW  = MW + CB;
    localparam int MMW  = 2 * CB + 10;
    localparam int SW   = 2 * CB + 6;
    localparam int RW   = plc_root_bits(CB);
    localparam int NW   = CB + 23;
    localparam int LAT  = plc_latency(CB);
    localparam int DLEN = 2 + RW + DIV_STAGES + POW_LAT;

    typedef struct packed {
        logic [MMW-1:0]       rem;
        logic [RW-1:0]        root;
        logic signed [SW-1:0] s;
    } sqrt_t;

    typedef struct packed {
        logic [NW-1:0] rem;
        logic [15:0]   q;
        logic [RW-1:0] mlen;
        logic          ok;
        logic          ovf;
    } div_t;

    // Colour side path: diffuse part per channel, plus what the specular part still needs.
    typedef struct packed {
        logic [2:0][21:0] a;
        logic [2:0][15:0] lc;
        logic [16:0]      vis;
    } side_t;

    typedef struct packed {
        logic [2:0][18:0] b;
        side_t            sd;
    } fin_t;

    // ------------------------------------------------------------------
    // Configuration registers and the valid line.
    // ------------------------------------------------------------------
    logic [15:0]    da_reg;
    logic [15:0]    sa_reg;
    logic [15:0]    sh_reg;
    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            da_reg <= DIFFUSE_ALBEDO_RST;
            sa_reg <= SPECULAR_ALBEDO_RST;
            sh_reg <= SHININESS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_DIFFUSE_ALBEDO:  da_reg <= cfg_data;
                CFG_SPECULAR_ALBEDO: sa_reg <= cfg_data;
                CFG_SHININESS:       sh_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], start & ~busy};
        end
    end

    // ------------------------------------------------------------------
    // Front end: unpack, dot products and the reflected vector.
    // Components above bit 47 of a packed word read as zero.
    // ------------------------------------------------------------------
    logic [XW-1:0]        nx;
    logic [XW-1:0]        lx;
    logic [XW-1:0]        vx;
    logic signed [CB-1:0] n_in [3];
    logic signed [CB-1:0] l_in [3];
    logic signed [CB-1:0] v_in [3];

    assign nx = XW'(normal_xyz);
    assign lx = XW'(light_dir_xyz);
    assign vx = XW'(view_dir_xyz);

    for (genvar i = 0; i < 3; i++)
    begin : g_unpack
        assign n_in[i] = $signed(nx[i*CB +: CB]);
        assign l_in[i] = $signed(lx[i*CB +: CB]);
        assign v_in[i] = $signed(vx[i*CB +: CB]);
    end

    logic signed [CB-1:0]  n1_reg [3];
    logic signed [CB-1:0]  l1_reg [3];
    logic signed [CB-1:0]  v1_reg [3];
    logic signed [PW2-1:0] pnl1_reg [3];
    logic signed [CB-1:0]  n2_reg [3];
    logic signed [CB-1:0]  l2_reg [3];
    logic signed [CB-1:0]  v2_reg [3];
    logic signed [DW-1:0]  dot2_reg;
    logic signed [DW-1:0]  dot2_next;
    logic signed [TW-1:0]  t3;
    logic signed [QW-1:0]  q3_reg [3];
    logic signed [CB-1:0]  l3_reg [3];
    logic signed [CB-1:0]  v3_reg [3];
    logic signed [MW-1:0]  m4_reg [3];
    logic signed [CB-1:0]  v4_reg [3];
    logic signed [SQW-1:0] sq5_reg [3];
    logic signed [MVW-1:0] mv5_reg [3];
    logic [MMW-1:0]        mm6_reg;
    logic [MMW-1:0]        mm6_next;
    logic signed [SW-1:0]  s6_reg;
    logic signed [SW-1:0]  s6_next;

    assign dot2_next = DW'(pnl1_reg[0]) + DW'(pnl1_reg[1]) + DW'(pnl1_reg[2]);
    assign t3        = TW'(dot2_reg >>> F);
    assign mm6_next  = MMW'($unsigned(sq5_reg[0])) + MMW'($unsigned(sq5_reg[1]))
                     + MMW'($unsigned(sq5_reg[2]));
    assign s6_next   = SW'(mv5_reg[0]) + SW'(mv5_reg[1]) + SW'(mv5_reg[2]);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            n1_reg[i]   <= n_in[i];
            l1_reg[i]   <= l_in[i];
            v1_reg[i]   <= v_in[i];
            pnl1_reg[i] <= PW2'(n_in[i]) * PW2'(l_in[i]);
            n2_reg[i]   <= n1_reg[i];
            l2_reg[i]   <= l1_reg[i];
            v2_reg[i]   <= v1_reg[i];
            // The factor two of the reflection folds into one less shift below.
            q3_reg[i]   <= QW'(t3) * QW'(n2_reg[i]);
            l3_reg[i]   <= l2_reg[i];
            v3_reg[i]   <= v2_reg[i];
            m4_reg[i]   <= MW'(q3_reg[i] >>> (F - 1)) - MW'(l3_reg[i]);
            v4_reg[i]   <= v3_reg[i];
            sq5_reg[i]  <= SQW'(m4_reg[i]) * SQW'(m4_reg[i]);
            mv5_reg[i]  <= MVW'(m4_reg[i]) * MVW'(v4_reg[i]);
        end
        dot2_reg <= dot2_next;
        mm6_reg  <= mm6_next;
        s6_reg   <= s6_next;
    end

    // ------------------------------------------------------------------
    // Length of the reflected vector: one result bit per stage.
    // ------------------------------------------------------------------
    sqrt_t sqr_reg [RW];

    for (genvar j = 0; j < RW; j++)
    begin : g_sqrt
        localparam int K = RW - 1 - j;
        sqrt_t sqr_in;
        sqrt_t sqr_next;
        if (j == 0)
        begin : g_first
            assign sqr_in = '{rem: mm6_reg, root: '0, s: s6_reg};
        end
        else
        begin : g_rest
            assign sqr_in = sqr_reg[j-1];
        end
        always_comb
        begin
            logic [MMW:0] test;
            test     = ((MMW+1)'(sqr_in.root) << (K + 1)) + ((MMW+1)'(1) << (2 * K));
            sqr_next = sqr_in;
            if ({1'b0, sqr_in.rem} >= test)
            begin
                sqr_next.rem  = MMW'({1'b0, sqr_in.rem} - test);
                sqr_next.root = sqr_in.root | (RW'(1) << K);
            end
        end
        always_ff @(posedge clk)
        begin
            sqr_reg[j] <= sqr_next;
        end
    end

    // ------------------------------------------------------------------
    // Cosine = floor(m.v) / |m| in Q.16, capped at one, by restoring division.
    // A negative m.v or a zero-length m gives no specular light at all.
    // ------------------------------------------------------------------
    div_t dv_prep_reg;
    div_t dv_prep_next;
    div_t dv_reg [16];

    always_comb
    begin
        dv_prep_next.mlen = sqr_reg[RW-1].root;
        dv_prep_next.ok   = !sqr_reg[RW-1].s[SW-1] && (sqr_reg[RW-1].root != '0);
        dv_prep_next.rem  = {sqr_reg[RW-1].s[SW-2:F], 16'b0};
        dv_prep_next.ovf  = dv_prep_next.rem >= NW'({sqr_reg[RW-1].root, 16'b0});
        dv_prep_next.q    = '0;
    end

    always_ff @(posedge clk)
    begin
        dv_prep_reg <= dv_prep_next;
    end

    for (genvar j = 0; j < 16; j++)
    begin : g_div
        localparam int K = 15 - j;
        div_t dv_in;
        div_t dv_next;
        if (j == 0)
        begin : g_first
            assign dv_in = dv_prep_reg;
        end
        else
        begin : g_rest
            assign dv_in = dv_reg[j-1];
        end
        always_comb
        begin
            logic [NW-1:0] test;
            test    = NW'(dv_in.mlen) << K;
            dv_next = dv_in;
            if (dv_in.rem >= test)
            begin
                dv_next.rem  = dv_in.rem - test;
                dv_next.q[K] = 1'b1;
            end
        end
        always_ff @(posedge clk)
        begin
            dv_reg[j] <= dv_next;
        end
    end

    logic [16:0] c16;
    logic        kill;
    logic [16:0] spec_w;

    assign c16  = dv_reg[15].ovf ? 17'h10000 : {1'b0, dv_reg[15].q};
    assign kill = !dv_reg[15].ok;

    plc_pow_unit u_pow
    (
        .clk       (clk),
        .c16       (c16),
        .kill      (kill),
        .shininess (sh_reg),
        .spec      (spec_w)
    );

    // ------------------------------------------------------------------
    // Diffuse side path, then a delay line that meets the specular factor.
    // ------------------------------------------------------------------
    logic [19:0] d16;
    side_t       sd1_reg;
    side_t       sd1_next;
    side_t       sd2_reg;
    side_t       sd2_next;
    side_t       sd3_reg;
    side_t       sd3_next;
    side_t       sd4_reg;
    side_t       sd4_next;
    side_t       dly_reg [DLEN];

    // Diffuse factor: n.l brought to Q.16, clamped at zero.
    assign d16 = (!dot2_reg[DW-1] && (dot2_reg != '0)) ? 20'(dot2_reg >>> (2 * F - 16)) : '0;

    always_comb
    begin
        logic [2:0][15:0] sc;
        logic [31:0]      p32;
        sc           = {surface_blue, surface_green, surface_red};
        sd1_next.lc  = {light_blue, light_green, light_red};
        sd1_next.vis = visibility;
        for (int c = 0; c < 3; c++)
        begin
            p32           = 32'(da_reg) * 32'(sc[c]);
            sd1_next.a[c] = 22'(p32[31:15]);
        end
    end

    always_comb
    begin
        logic [32:0] p33;
        logic [36:0] p37;
        logic [37:0] p38;
        sd2_next = sd1_reg;
        sd3_next = sd2_reg;
        sd4_next = sd3_reg;
        for (int c = 0; c < 3; c++)
        begin
            p33           = 33'(sd1_reg.a[c][16:0]) * 33'(sd1_reg.lc[c]);
            sd2_next.a[c] = 22'(p33[32:16]);
            p37           = 37'(sd2_reg.a[c][16:0]) * 37'(d16);
            sd3_next.a[c] = 22'(p37[36:16]);
            p38           = 38'(sd3_reg.a[c][20:0]) * 38'(sd3_reg.vis);
            sd4_next.a[c] = p38[37:16];
        end
    end

    always_ff @(posedge clk)
    begin
        sd1_reg    <= sd1_next;
        sd2_reg    <= sd2_next;
        sd3_reg    <= sd3_next;
        sd4_reg    <= sd4_next;
        dly_reg[0] <= sd4_reg;
        for (int k = 1; k < DLEN; k++)
        begin
            dly_reg[k] <= dly_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Specular colour, then the saturating sum per channel.
    // ------------------------------------------------------------------
    fin_t             f1_reg;
    fin_t             f1_next;
    fin_t             f2_reg;
    fin_t             f2_next;
    fin_t             f3_reg;
    fin_t             f3_next;
    logic [2:0][17:0] add_reg;
    logic [2:0][17:0] add_next;

    always_comb
    begin
        logic [32:0] p33;
        logic [33:0] p34;
        logic [34:0] p35;
        logic [22:0] sum;
        f1_next.sd = dly_reg[DLEN-1];
        f2_next    = f1_reg;
        f3_next    = f2_reg;
        for (int c = 0; c < 3; c++)
        begin
            p33           = 33'(spec_w) * 33'(sa_reg);
            f1_next.b[c]  = 19'(p33[32:15]);
            p34           = 34'(f1_reg.b[c][17:0]) * 34'(f1_reg.sd.lc[c]);
            f2_next.b[c]  = 19'(p34[33:16]);
            p35           = 35'(f2_reg.b[c][17:0]) * 35'(f2_reg.sd.vis);
            f3_next.b[c]  = p35[34:16];
            sum           = 23'(f3_reg.sd.a[c]) + 23'(f3_reg.b[c]);
            add_next[c]   = (sum > 23'(OUT_MAX)) ? OUT_MAX : sum[17:0];
        end
    end

    always_ff @(posedge clk)
    begin
        f1_reg  <= f1_next;
        f2_reg  <= f2_next;
        f3_reg  <= f3_next;
        add_reg <= add_next;
    end

    assign done      = vld_reg[LAT-1];
    assign add_red   = add_reg[0];
    assign add_green = add_reg[1];
    assign add_blue  = add_reg[2];

endmodule

// ----- rtl/core/plc_checker.sv -----
// Port-level checker for the Phong light contribution core, with its bind statement.
// Depends on plc_pkg for the pipeline latency.
module plc_checker
    import plc_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [16:0] visibility,
    input logic [17:0] add_red,
    input logic [17:0] add_green,
    input logic [17:0] add_blue
);

    localparam int LAT = plc_latency(COMPONENT_BITS);

    // No result strobe while reset is applied.
    a_no_done_in_reset: assert property (@(posedge clk) !rst_n |-> !done)
        else $error("result strobe during reset");

    // Every accepted beat comes back after exactly the pipeline latency.
    a_beat_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted beat did not return on time");

    // No result beat appears without a request beat the latency before it.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && rst_n, LAT))
        else $error("result beat without a request");

    // A fully shadowed point adds no light.
    a_shadow_black: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(start && !busy && (visibility == 17'd0), LAT))
        |-> (add_red == 18'd0) && (add_green == 18'd0) && (add_blue == 18'd0))
        else $error("shadowed point gave nonzero colour");

endmodule

bind phong_light_contribution_core plc_checker #(.COMPONENT_BITS(COMPONENT_BITS)) u_plc_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .visibility (visibility),
    .add_red    (add_red),
    .add_green  (add_green),
    .add_blue   (add_blue)
);
